[src/uml_pkg.sv]
// ----------------------------------------------------------------------------
// uml_pkg
// shared types and constants of the serial memory loader
// ----------------------------------------------------------------------------
package uml_pkg;

    // reply codes and masks
    localparam logic [31:0] C_ADDR_MASK  = 32'hF000_0000;
    localparam logic [31:0] C_LEN_FLAG   = 32'h4000_0000;
    localparam logic [31:0] C_LEN_MASK   = 32'h0FFF_FFFF;
    localparam logic [31:0] C_BAD_ADDR   = 32'hFFFF_FFF8;
    localparam logic [31:0] C_BAD_LEN    = 32'hFFFF_FFF4;
    localparam logic [31:0] C_LOAD_DONE  = 32'hFFFF_FFFF;
    localparam logic [31:0] C_PTR_RESET  = 32'h8000_0000;
    localparam logic [31:0] C_ADDR_STEP  = 32'd4;

    localparam int C_COUNT_W = 26;

    // result kinds
    localparam logic C_KIND_REPLY = 1'b0;
    localparam logic C_KIND_WRITE = 1'b1;

    // command from the front part to the back part
    typedef enum logic [1:0] {
        OP_REPLY1,     // one reply, word in a
        OP_REPLY3,     // three replies a, b, c
        OP_WRITE,      // memory write, address a, data b
        OP_WRITE_END   // memory write then done reply
    } t_op;

    typedef struct packed {
        t_op         op;
        logic [31:0] a;
        logic [31:0] b;
        logic [31:0] c;
    } t_cmd;

endpackage

[src/uml_front.sv]
// ----------------------------------------------------------------------------
// uml_front
// packs bytes into words, tracks the load phase and issues commands
// ----------------------------------------------------------------------------
module uml_front (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_accept,
    input  logic [7:0]    i_rx_byte,
    output logic          o_push,
    output uml_pkg::t_cmd o_cmd
);
    import uml_pkg::*;

    typedef enum logic [1:0] {
        PH_ADDR,
        PH_LEN,
        PH_LOAD
    } t_phase;

    logic [1:0]           r_bytes_held, n_bytes_held;
    logic [23:0]          r_partial,    n_partial;
    t_phase               r_phase,      n_phase;
    logic [31:0]          r_wp,         n_wp;
    logic [C_COUNT_W-1:0] r_wl,         n_wl;
    logic                 r_push,       n_push;
    t_cmd                 r_cmd,        n_cmd;

    logic [31:0]          w_word;
    logic [31:0]          w_len;
    logic [C_COUNT_W-1:0] w_wl_dec;

    assign w_word   = {r_partial, i_rx_byte};
    assign w_len    = w_word & C_LEN_MASK;
    assign w_wl_dec = r_wl - C_COUNT_W'(1);

    always_comb begin
        n_bytes_held = r_bytes_held;
        n_partial    = r_partial;
        n_phase      = r_phase;
        n_wp         = r_wp;
        n_wl         = r_wl;
        n_push       = 1'b0;
        n_cmd        = r_cmd;
        if (i_accept) begin
            if (r_bytes_held != 2'd3) begin
                n_partial    = {r_partial[15:0], i_rx_byte};
                n_bytes_held = r_bytes_held + 2'd1;
            end else begin
                n_partial    = '0;
                n_bytes_held = '0;
                unique case (r_phase)
                    PH_ADDR: begin
                        if ((w_word & C_ADDR_MASK) != '0) begin
                            n_wp    = w_word;
                            n_phase = PH_LEN;
                        end else begin
                            n_push  = 1'b1;
                            n_cmd   = '{op: OP_REPLY1, a: C_BAD_ADDR, b: '0, c: '0};
                        end
                    end
                    PH_LEN: begin
                        n_push = 1'b1;
                        if ((w_word & C_LEN_FLAG) != '0) begin
                            n_wl    = w_len[C_COUNT_W+1:2];
                            n_phase = PH_LOAD;
                            n_cmd   = '{op: OP_REPLY3, a: w_len + r_wp, b: r_wp,
                                        c: 32'(w_len[C_COUNT_W+1:2])};
                        end else begin
                            n_phase = PH_ADDR;
                            n_cmd   = '{op: OP_REPLY3, a: C_BAD_LEN, b: r_wp,
                                        c: 32'(r_wl)};
                        end
                    end
                    PH_LOAD: begin
                        n_push = 1'b1;
                        if (r_wl == '0) begin
                            // zero count ends the load at once
                            n_phase = PH_ADDR;
                            n_cmd   = '{op: OP_REPLY1, a: C_LOAD_DONE, b: '0, c: '0};
                        end else begin
                            n_wp  = r_wp + C_ADDR_STEP;
                            n_wl  = w_wl_dec;
                            n_cmd = '{op: OP_WRITE, a: r_wp, b: w_word, c: '0};
                            if (w_wl_dec == '0) begin
                                n_phase  = PH_ADDR;
                                n_cmd.op = OP_WRITE_END;
                            end
                        end
                    end
                    default: begin
                        n_phase = PH_ADDR;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bytes_held <= '0;
            r_partial    <= '0;
            r_phase      <= PH_ADDR;
            r_wp         <= C_PTR_RESET;
            r_wl         <= '0;
            r_push       <= 1'b0;
        end else begin
            r_bytes_held <= n_bytes_held;
            r_partial    <= n_partial;
            r_phase      <= n_phase;
            r_wp         <= n_wp;
            r_wl         <= n_wl;
            r_push       <= n_push;
        end
        r_cmd <= n_cmd;
    end

    assign o_push = r_push;
    assign o_cmd  = r_cmd;

endmodule

[src/uml_fifo.sv]
// ----------------------------------------------------------------------------
// uml_fifo
// short command queue between the front and back parts
// ----------------------------------------------------------------------------
module uml_fifo #(
    parameter int P_DEPTH = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_push,
    input  uml_pkg::t_cmd i_cmd,
    input  logic          i_pop,
    output logic          o_empty,
    output logic          o_full,
    output uml_pkg::t_cmd o_cmd
);
    import uml_pkg::*;

    localparam int PW = $clog2(P_DEPTH);
    localparam int CW = $clog2(P_DEPTH + 1);

    t_cmd          r_mem [P_DEPTH];
    logic [PW-1:0] r_wr_ptr, n_wr_ptr;
    logic [PW-1:0] r_rd_ptr, n_rd_ptr;
    logic [CW-1:0] r_count,  n_count;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (i_push) begin
            n_wr_ptr = (r_wr_ptr == PW'(P_DEPTH - 1)) ? '0 : r_wr_ptr + PW'(1);
        end
        if (i_pop) begin
            n_rd_ptr = (r_rd_ptr == PW'(P_DEPTH - 1)) ? '0 : r_rd_ptr + PW'(1);
        end
        if (i_push && !i_pop) begin
            n_count = r_count + CW'(1);
        end else if (i_pop && !i_push) begin
            n_count = r_count - CW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_cmd;
        end
    end

    assign o_empty = (r_count == '0);
    assign o_full  = (r_count == CW'(P_DEPTH));
    assign o_cmd   = r_mem[r_rd_ptr];

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> (!o_full || i_pop))
        else $error("command queue overflow");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_pop |-> !o_empty)
        else $error("command queue underflow");

    a_count_up: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_push && !i_pop) |=> (r_count == $past(r_count) + CW'(1)))
        else $error("command queue count lost a push");

endmodule

[src/uml_back.sv]
// ----------------------------------------------------------------------------
// uml_back
// expands queued commands into result words through an output register
// ----------------------------------------------------------------------------
module uml_back (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_empty,
    input  uml_pkg::t_cmd i_cmd,
    output logic          o_pop,
    input  logic          i_stall,
    output logic          o_valid,
    output logic          o_kind,
    output logic [31:0]   o_mem_address,
    output logic [31:0]   o_word,
    output logic          o_last
);
    import uml_pkg::*;

    logic [1:0]  r_idx, n_idx;
    logic        r_valid;
    logic        r_kind;
    logic [31:0] r_addr;
    logic [31:0] r_word;
    logic        r_last;

    logic        w_advance;
    logic        w_kind;
    logic [31:0] w_addr;
    logic [31:0] w_word;
    logic        w_last;

    assign w_advance = !r_valid || !i_stall;

    // result selected by the head command and the result index
    always_comb begin
        w_kind = C_KIND_REPLY;
        w_addr = '0;
        w_word = i_cmd.a;
        w_last = 1'b1;
        unique case (i_cmd.op)
            OP_REPLY1: begin
                w_word = i_cmd.a;
            end
            OP_REPLY3: begin
                w_last = (r_idx == 2'd2);
                priority case (r_idx)
                    2'd0:    w_word = i_cmd.a;
                    2'd1:    w_word = i_cmd.b;
                    default: w_word = i_cmd.c;
                endcase
            end
            OP_WRITE: begin
                w_kind = C_KIND_WRITE;
                w_addr = i_cmd.a;
                w_word = i_cmd.b;
            end
            OP_WRITE_END: begin
                if (r_idx == 2'd0) begin
                    w_kind = C_KIND_WRITE;
                    w_addr = i_cmd.a;
                    w_word = i_cmd.b;
                    w_last = 1'b0;
                end else begin
                    w_word = C_LOAD_DONE;
                end
            end
            default: begin
                w_word = i_cmd.a;
            end
        endcase
    end

    assign o_pop = w_advance && !i_empty && w_last;

    always_comb begin
        n_idx = r_idx;
        if (w_advance && !i_empty) begin
            n_idx = w_last ? 2'd0 : r_idx + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_idx   <= '0;
            r_valid <= 1'b0;
        end else begin
            r_idx <= n_idx;
            if (w_advance) begin
                r_valid <= !i_empty;
            end
        end
        if (w_advance) begin
            r_kind <= w_kind;
            r_addr <= w_addr;
            r_word <= w_word;
            r_last <= w_last;
        end
    end

    assign o_valid       = r_valid;
    assign o_kind        = r_kind;
    assign o_mem_address = r_addr;
    assign o_word        = r_word;
    assign o_last        = r_last;

endmodule

[src/uart_memory_loader_top.sv]
// ----------------------------------------------------------------------------
// uart_memory_loader_top
// serial loader: packs received bytes into words, replies and writes memory
// ----------------------------------------------------------------------------
//  channel   direction  handshake           payload
//  input     in         i_valid / o_stall   i_rx_byte
//  output    out        o_valid / i_stall   o_kind, o_mem_address, o_word, o_last
//
//  a byte is taken in any cycle while the command queue has room; a byte
//  that completes a word passes the front's command register into the
//  queue, and its first result word waits in the back's output register
//  the back part sends one result word per cycle while i_stall is low, so
//  a completed word gives 0 to 3 result words (3 after a length word)
//  reset is synchronous, active low; it clears phase, counts, queue and valid
//  o_stall is high while the queue is full, or has one free slot with a
//  command still on its way in; a stalled output holds its word while the
//  front keeps taking bytes until the queue fills
// ----------------------------------------------------------------------------
module uart_memory_loader_top #(
    parameter int P_QUEUE_DEPTH = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_rx_byte,
    output logic        o_valid,
    input  logic        i_stall,
    output logic        o_kind,
    output logic [31:0] o_mem_address,
    output logic [31:0] o_word,
    output logic        o_last
);
    import uml_pkg::*;

    logic w_accept;
    logic w_push;
    logic w_pop;
    logic w_empty;
    logic w_full;
    logic w_q_full;
    t_cmd w_front_cmd;
    t_cmd w_head_cmd;

    // commands held in the queue
    logic [$clog2(P_QUEUE_DEPTH + 1)-1:0] r_used;

    // front stalls when the queue cannot take one more command
    assign o_stall  = w_full;
    assign w_accept = i_valid && !w_full;

    // byte packing, phase tracking and command issue
    uml_front u_front (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_accept  (w_accept),
        .i_rx_byte (i_rx_byte),
        .o_push    (w_push),
        .o_cmd     (w_front_cmd)
    );

    // command queue; one slot is kept for the push already in flight
    uml_fifo #(
        .P_DEPTH (P_QUEUE_DEPTH)
    ) u_fifo (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .i_cmd   (w_front_cmd),
        .i_pop   (w_pop),
        .o_empty (w_empty),
        .o_full  (w_q_full),
        .o_cmd   (w_head_cmd)
    );

    // queue occupancy, kept here to see the registered push coming in
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_used <= '0;
        end else if (w_push && !w_pop) begin
            r_used <= r_used + $bits(r_used)'(1);
        end else if (w_pop && !w_push) begin
            r_used <= r_used - $bits(r_used)'(1);
        end
    end

    // full, or last slot already claimed by the push in flight
    assign w_full = w_q_full ||
                    (w_push && (r_used == $bits(r_used)'(P_QUEUE_DEPTH - 1)));

    // result expansion and output register
    uml_back u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_empty       (w_empty),
        .i_cmd         (w_head_cmd),
        .o_pop         (w_pop),
        .i_stall       (i_stall),
        .o_valid       (o_valid),
        .o_kind        (o_kind),
        .o_mem_address (o_mem_address),
        .o_word        (o_word),
        .o_last        (o_last)
    );

endmodule
